// File: rtl/core/abd_pkg.sv
// Shared types, constants and table functions of the anchor box decoder.
package abd_pkg;

  localparam int unsigned LevelW = 3;
  localparam int unsigned GridW  = 11;
  localparam int unsigned LabelW = 7;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned CoordW = 24;

  typedef enum logic [2:0] {
    REG_SCORE_THRESHOLD    = 3'd0,
    REG_INPUT_HEIGHT       = 3'd1,
    REG_INPUT_WIDTH        = 3'd2,
    REG_SCALE_HEIGHT       = 3'd3,
    REG_SCALE_WIDTH        = 3'd4,
    REG_ANCHOR_SIZE_FACTOR = 3'd5,
    REG_BOX_LIMIT          = 3'd6
  } abd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_SIZE,
    ST_CENTER,
    ST_EXPMUL,
    ST_SUM,
    ST_EDGE,
    ST_OUT
  } abd_state_e;

  typedef struct packed {
    logic       in_ready;
    abd_state_e step;
    logic       load_out;
  } abd_cmd_t;

  typedef struct packed {
    logic start;
    logic out_busy;
  } abd_status_t;

  // Anchor scales in Q2.14 and aspect ratios in Q2.12.
  localparam logic [15:0] ScaleQ14 [4] = '{16'd16384, 16'd20643, 16'd26008, 16'd32768};
  localparam logic [13:0] RatioXQ12 [4] = '{14'd4096, 14'd5734, 14'd2867, 14'd8192};
  localparam logic [13:0] RatioYQ12 [4] = '{14'd4096, 14'd2867, 14'd5734, 14'd2048};

  // Unsigned quotient by shift and subtract, used only while building tables.
  function automatic longint unsigned abd_udiv(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One exp() table entry in Q12.20, evaluated at elaboration only.
  function automatic logic [31:0] abd_exp_entry(input int unsigned idx,
                                                input int unsigned depth);
    longint          num;
    longint unsigned a;
    longint unsigned y;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned res;
    num  = 16 * longint'(idx) - 8 * longint'(depth);
    a    = (num < 0) ? longint'(-num) : longint'(num);
    y    = abd_udiv(a << 20, 64'(depth));
    sum  = 64'd1 << 24;
    term = 64'd1 << 24;
    for (int n = 1; n <= 30; n++) begin
      term = abd_udiv((term * y) >> 24, 64'(n));
      sum  = sum + term;
    end
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum + (64'd1 << 23)) >> 24;
    end
    if (num >= 0) begin
      res = (sum + 64'd8) >> 4;
    end else begin
      res = abd_udiv((64'd1 << 44) + (sum >> 1), sum);
    end
    return res[31:0];
  endfunction

endpackage

// File: rtl/core/abd_ctrl.sv
// Sequencer that steps the box decode through its multiply stages.
module abd_ctrl
  import abd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  abd_status_t status_i,
  output abd_cmd_t    cmd_o
);

  abd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (status_i.start) state_d = ST_BASE;
      ST_BASE:   state_d = ST_SIZE;
      ST_SIZE:   state_d = ST_CENTER;
      ST_CENTER: state_d = ST_EXPMUL;
      ST_EXPMUL: state_d = ST_SUM;
      ST_SUM:    state_d = ST_EDGE;
      ST_EDGE:   state_d = ST_OUT;
      ST_OUT:    if (!status_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.in_ready = (state_q == ST_IDLE);
    cmd_o.step     = state_q;
    cmd_o.load_out = (state_q == ST_OUT) && !status_i.out_busy;
  end

`ifndef SYNTHESIS
  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.start |-> state_q == ST_IDLE) else $error("decode started while busy");
  a_start_goes_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.start |=> state_q == ST_BASE) else $error("decode did not begin");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && status_i.out_busy) |=> state_q == ST_OUT)
    else $error("result dropped while output full");
`endif

endmodule

// File: rtl/core/abd_datapath.sv
// Argmax, anchor grid counters, configuration registers and box decode arithmetic.
module abd_datapath
  import abd_pkg::*;
#(
  parameter int unsigned NUM_LEVELS      = 5,
  parameter int unsigned NUM_SCALES      = 3,
  parameter int unsigned NUM_RATIOS      = 3,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  abd_cmd_t     cmd_i,
  output abd_status_t  status_o,
  input  logic         cfg_valid_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         in_valid_i,
  input  logic         frame_start_i,
  input  logic         class_last_i,
  input  logic [15:0]  class_score_i,
  input  logic signed [15:0] delta_y_i,
  input  logic signed [15:0] delta_x_i,
  input  logic signed [15:0] delta_h_i,
  input  logic signed [15:0] delta_w_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [119:0] out_data_o
);

  localparam int unsigned IdxW = $clog2(EXP_TABLE_DEPTH);

  // Configuration registers.
  logic [15:0] thr_q, sh_q, sw_q, lim_q;
  logic [11:0] ih_q, iw_q;
  logic [7:0]  fac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd13107;
      ih_q  <= 12'd1536;
      iw_q  <= 12'd1536;
      sh_q  <= 16'd256;
      sw_q  <= 16'd256;
      fac_q <= 8'd64;
      lim_q <= 16'd30000;
    end else if (cfg_valid_i) begin
      unique case (abd_reg_e'(cfg_index_i))
        REG_SCORE_THRESHOLD:    thr_q <= cfg_data_i;
        REG_INPUT_HEIGHT:       ih_q  <= cfg_data_i[11:0];
        REG_INPUT_WIDTH:        iw_q  <= cfg_data_i[11:0];
        REG_SCALE_HEIGHT:       sh_q  <= cfg_data_i;
        REG_SCALE_WIDTH:        sw_q  <= cfg_data_i;
        REG_ANCHOR_SIZE_FACTOR: fac_q <= cfg_data_i[7:0];
        REG_BOX_LIMIT:          lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stream state.
  logic [ScoreW-1:0] best_q, best_d;
  logic [LabelW-1:0] label_q, label_d, pos_q, pos_d;
  logic [LevelW-1:0] lvl_q, lvl_d;
  logic [GridW-1:0]  row_q, row_d, col_q, col_d;
  logic [1:0]        si_q, si_d, ri_q, ri_d;
  logic [16:0]       boxes_q, boxes_d;
  logic              limit_q, limit_d;

  logic [7:0]        lvl_ok;
  logic [LevelW-1:0] first_lvl, wrap_lvl, cand;
  logic [LevelW-1:0] b_lvl;
  logic [GridW-1:0]  b_row, b_col, col_inc, row_inc;
  logic [1:0]        b_si, b_ri;
  logic [LabelW-1:0] pos_eff;
  logic [16:0]       b_boxes;
  logic              b_limit, accept, emit;
  logic [2:0]        ri_inc, si_inc;
  logic [20:0]       col_edge, row_edge;
  logic [3:0]        sh3;

  always_comb begin
    lvl_ok = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lvl_ok[l] = ((12'd4 << l) < ih_q) && ((12'd4 << l) < iw_q);
    end
  end

  assign accept = in_valid_i && cmd_i.in_ready;

  always_comb begin
    first_lvl = '0;
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      if (lvl_ok[k]) first_lvl = LevelW'(k);
    end
  end

  assign b_lvl   = frame_start_i ? first_lvl : lvl_q;
  assign b_row   = frame_start_i ? '0 : row_q;
  assign b_col   = frame_start_i ? '0 : col_q;
  assign b_si    = frame_start_i ? '0 : si_q;
  assign b_ri    = frame_start_i ? '0 : ri_q;
  assign pos_eff = frame_start_i ? '0 : pos_q;
  assign b_boxes = frame_start_i ? '0 : boxes_q;
  assign b_limit = frame_start_i ? 1'b0 : limit_q;

  // Next non-empty level after the current one, wrapping around.
  always_comb begin
    wrap_lvl = '0;
    cand     = '0;
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      if (32'(b_lvl) + 32'd1 + 32'(k) >= NUM_LEVELS) begin
        cand = LevelW'(32'(b_lvl) + 32'd1 + 32'(k) - NUM_LEVELS);
      end else begin
        cand = LevelW'(32'(b_lvl) + 32'd1 + 32'(k));
      end
      if (lvl_ok[cand]) wrap_lvl = cand;
    end
  end

  assign sh3      = {1'b0, b_lvl} + 4'd3;
  assign col_inc  = b_col + 11'd1;
  assign row_inc  = b_row + 11'd1;
  assign col_edge = (21'd4 << b_lvl) + (21'(col_inc) << sh3);
  assign row_edge = (21'd4 << b_lvl) + (21'(row_inc) << sh3);
  assign ri_inc   = {1'b0, b_ri} + 3'd1;
  assign si_inc   = {1'b0, b_si} + 3'd1;

  always_comb begin
    best_d  = best_q;
    label_d = label_q;
    if (pos_eff == '0) begin
      best_d  = class_score_i;
      label_d = '0;
    end else if (class_score_i > best_q) begin
      best_d  = class_score_i;
      label_d = pos_eff;
    end
    emit    = class_last_i && !b_limit && (best_d >= thr_q);
    lvl_d   = b_lvl;
    row_d   = b_row;
    col_d   = b_col;
    si_d    = b_si;
    ri_d    = b_ri;
    boxes_d = b_boxes;
    limit_d = b_limit;
    pos_d   = pos_eff + 7'd1;
    if (class_last_i) begin
      pos_d = '0;
      if (emit) begin
        boxes_d = b_boxes + 17'd1;
        limit_d = (b_boxes + 17'd1) > {1'b0, lim_q};
      end
      if (32'(ri_inc) < NUM_RATIOS) begin
        ri_d = ri_inc[1:0];
      end else begin
        ri_d = '0;
        if (32'(si_inc) < NUM_SCALES) begin
          si_d = si_inc[1:0];
        end else begin
          si_d  = '0;
          col_d = col_inc;
          if (col_edge >= {9'd0, iw_q}) begin
            col_d = '0;
            row_d = row_inc;
            if (row_edge >= {9'd0, ih_q}) begin
              row_d = '0;
              lvl_d = wrap_lvl;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      label_q <= '0;
      pos_q   <= '0;
      lvl_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      si_q    <= '0;
      ri_q    <= '0;
      boxes_q <= '0;
      limit_q <= 1'b0;
    end else if (accept) begin
      best_q  <= best_d;
      label_q <= label_d;
      pos_q   <= pos_d;
      lvl_q   <= lvl_d;
      row_q   <= row_d;
      col_q   <= col_d;
      si_q    <= si_d;
      ri_q    <= ri_d;
      boxes_q <= boxes_d;
      limit_q <= limit_d;
    end
  end

  assign status_o.start = accept && emit;

  // Exp table as constant logic.
  logic [31:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_exp
    assign exp_rom[gi] = abd_exp_entry(gi, EXP_TABLE_DEPTH);
  end

  function automatic logic [IdxW-1:0] exp_index(input logic [15:0] d);
    logic [29:0] prod;
    logic [13:0] full;
    prod = 30'({~d[15], d[14:0]}) * 30'(EXP_TABLE_DEPTH) + 30'd32768;
    full = prod[29:16];
    if (32'(full) >= EXP_TABLE_DEPTH) begin
      return IdxW'(EXP_TABLE_DEPTH - 1);
    end
    return full[IdxW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] sat24(input logic signed [41:0] v);
    if (v > 42'sd8388607) return 24'h7FFFFF;
    if (v < -42'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // Decode operands captured with the emitting item.
  logic [LevelW-1:0] d_lvl_q;
  logic [GridW-1:0]  d_row_q, d_col_q;
  logic [1:0]        d_si_q, d_ri_q;
  logic [15:0]       d_dy_q, d_dx_q, d_dh_q, d_dw_q;
  logic [ScoreW-1:0] d_score_q;
  logic [LabelW-1:0] d_label_q;

  logic [31:0]        base_q, ey_q, ex_q;
  logic [32:0]        cya_q, cxa_q;
  logic [27:0]        ha_q, wa_q;
  logic signed [34:0] cy_q, cx_q;
  logic [45:0]        hlo_q, hhi_q, wlo_q, whi_q;
  logic [39:0]        h_q, w_q;
  logic signed [58:0] pl_q, pt_q, pr_q, pb_q;

  logic [3:0]         d_sh3;
  logic [16:0]        p1;
  logic [45:0]        ha_full, wa_full;
  logic signed [44:0] py, px, ry, rx;
  logic [59:0]        hsum, wsum;
  logic signed [41:0] vl, vt, vr, vb;
  logic signed [16:0] ssw, ssh;
  logic signed [58:0] rl, rt, rr, rb;

  assign d_sh3   = {1'b0, d_lvl_q} + 4'd3;
  assign p1      = 17'(fac_q) << d_sh3;
  assign ha_full = 46'(base_q) * 46'(RatioYQ12[d_ri_q]) + 46'd131072;
  assign wa_full = 46'(base_q) * 46'(RatioXQ12[d_ri_q]) + 46'd131072;
  assign py      = $signed(d_dy_q) * $signed({1'b0, ha_q});
  assign px      = $signed(d_dx_q) * $signed({1'b0, wa_q});
  assign ry      = (py + 45'sd2048) >>> 12;
  assign rx      = (px + 45'sd2048) >>> 12;
  assign hsum    = 60'(hlo_q) + (60'(hhi_q) << 14) + 60'd524288;
  assign wsum    = 60'(wlo_q) + (60'(whi_q) << 14) + 60'd524288;
  assign vl      = (42'(cx_q) <<< 1) - $signed({2'b00, w_q});
  assign vr      = (42'(cx_q) <<< 1) + $signed({2'b00, w_q});
  assign vt      = (42'(cy_q) <<< 1) - $signed({2'b00, h_q});
  assign vb      = (42'(cy_q) <<< 1) + $signed({2'b00, h_q});
  assign ssw     = $signed({1'b0, sw_q});
  assign ssh     = $signed({1'b0, sh_q});
  assign rl      = (pl_q + 59'sd65536) >>> 17;
  assign rt      = (pt_q + 59'sd65536) >>> 17;
  assign rr      = (pr_q + 59'sd65536) >>> 17;
  assign rb      = (pb_q + 59'sd65536) >>> 17;

  always_ff @(posedge clk_i) begin
    if (status_o.start) begin
      d_lvl_q   <= b_lvl;
      d_row_q   <= b_row;
      d_col_q   <= b_col;
      d_si_q    <= b_si;
      d_ri_q    <= b_ri;
      d_dy_q    <= delta_y_i;
      d_dx_q    <= delta_x_i;
      d_dh_q    <= delta_h_i;
      d_dw_q    <= delta_w_i;
      d_score_q <= best_d;
      d_label_q <= label_d;
    end
    unique case (cmd_i.step)
      ST_BASE: begin
        base_q <= 32'(34'(p1) * 34'(ScaleQ14[d_si_q]));
        cya_q  <= {(21'd4 << d_lvl_q) + (21'(d_row_q) << d_sh3), 12'd0};
        cxa_q  <= {(21'd4 << d_lvl_q) + (21'(d_col_q) << d_sh3), 12'd0};
      end
      ST_SIZE: begin
        ha_q <= ha_full[45:18];
        wa_q <= wa_full[45:18];
      end
      ST_CENTER: begin
        cy_q <= $signed({2'b00, cya_q}) + 35'(ry);
        cx_q <= $signed({2'b00, cxa_q}) + 35'(rx);
        ey_q <= exp_rom[exp_index(d_dh_q)];
        ex_q <= exp_rom[exp_index(d_dw_q)];
      end
      ST_EXPMUL: begin
        hlo_q <= 46'(ey_q) * 46'(ha_q[13:0]);
        hhi_q <= 46'(ey_q) * 46'(ha_q[27:14]);
        wlo_q <= 46'(ex_q) * 46'(wa_q[13:0]);
        whi_q <= 46'(ex_q) * 46'(wa_q[27:14]);
      end
      ST_SUM: begin
        h_q <= hsum[59:20];
        w_q <= wsum[59:20];
      end
      ST_EDGE: begin
        pl_q <= vl * ssw;
        pr_q <= vr * ssw;
        pt_q <= vt * ssh;
        pb_q <= vb * ssh;
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_data_o <= {1'b0, d_label_q, d_score_q, sat24(42'(rb)), sat24(42'(rr)),
                     sat24(42'(rt)), sat24(42'(rl))};
    end
  end

  // The output register lets the block keep taking scores while a box waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_o && !out_ready_i;

`ifndef SYNTHESIS
  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q |-> boxes_q != '0) else $error("limit set with no boxes counted");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lvl_q) < NUM_LEVELS) else $error("level counter out of range");
  a_no_emit_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (limit_q && !frame_start_i) |-> !emit) else $error("box emitted past limit");
`endif

endmodule

// File: rtl/core/anchor_box_decode_unit.sv
// Top level of the streaming anchor box decoder.
//
// Usage: class scores stream in on the s_axis channel, one item per score, all
// scores of one anchor in turn; tlast marks an anchor's last score and tuser
// marks the first score of a frame. On the last score, the four deltas in
// tdata are used. While the box count has not passed the box limit, anchors
// whose best score reaches the threshold come out as one item on the m_axis
// channel with edges, score and label. Configuration registers are written
// over the cfg channel, which is always ready; write them only while the
// block is idle. Throughput: a score that does not end a passing anchor
// takes one cycle while no decode is in progress. The last score of a
// passing anchor holds the input while the decode steps through its base,
// size, center, exp multiply, sum and edge states, until the box is loaded
// into the output register, whose valid flag drives m_axis_tvalid.
// If the receiver stalls, the box waits in the output register and scores
// keep flowing; a second passing anchor waits in the final decode step.
// Reset clears counters, box count and output valid and loads the
// register defaults; no clearing pass is needed.
module anchor_box_decode_unit
  import abd_pkg::*;
#(
  parameter int unsigned NUM_LEVELS      = 5,
  parameter int unsigned NUM_SCALES      = 3,
  parameter int unsigned NUM_RATIOS      = 3,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // class_score, delta_y, delta_x, delta_h, delta_w
  input  logic [79:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  // frame_start
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // box_left, box_top, box_right, box_bottom, box_score, box_label, one pad bit
  output logic [119:0] m_axis_tdata
);

  abd_cmd_t    cmd;
  abd_status_t status;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  abd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  abd_datapath #(
    .NUM_LEVELS      (NUM_LEVELS),
    .NUM_SCALES      (NUM_SCALES),
    .NUM_RATIOS      (NUM_RATIOS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .frame_start_i (s_axis_tuser),
    .class_last_i  (s_axis_tlast),
    .class_score_i (s_axis_tdata[15:0]),
    .delta_y_i     (s_axis_tdata[31:16]),
    .delta_x_i     (s_axis_tdata[47:32]),
    .delta_h_i     (s_axis_tdata[63:48]),
    .delta_w_i     (s_axis_tdata[79:64]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (m_axis_tdata)
  );

endmodule
